/* sv/mvn_pkg.sv */
// mvn_pkg: shared constants, codes and the command type for the vertex normal engine.
// Used by every module of the block; depends on nothing.
package mvn_pkg;

	localparam int MAX_VERTS  = 1024;
	localparam int IDX_W      = $clog2(MAX_VERTS);
	localparam int CNT_W      = $clog2(MAX_VERTS + 1);
	localparam int COORD_BITS = 16;
	localparam int POS_W      = 3 * COORD_BITS;
	localparam int ACC_W      = 48;
	localparam int NRM_W      = 16;
	localparam int ONE_Q14    = 16384;

	// request type codes on the input channel
	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_FACE   = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_UNUSED = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;
	localparam logic [1:0] ST_ZERO   = 2'd3;

	// command kinds queued between front and back
	localparam logic [2:0] K_APPEND = 3'd0;
	localparam logic [2:0] K_FACE   = 3'd1;
	localparam logic [2:0] K_QUERY  = 3'd2;
	localparam logic [2:0] K_CLEAR  = 3'd3;
	localparam logic [2:0] K_REPLY  = 3'd4;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [2:0]       kind;
		logic [1:0]       status;
		logic [IDX_W-1:0] idx_a;
		logic [IDX_W-1:0] idx_b;
		logic [IDX_W-1:0] idx_c;
		logic [POS_W-1:0] pos;
	} cmd_t;

endpackage

/* sv/mesh_vertex_normal_engine.sv */
// mesh_vertex_normal_engine: top level of the per-vertex normal engine.
// Joins mvn_front, mvn_queue and mvn_back; depends on mvn_pkg.
//
//   channel    handshake              payload
//   request    req_valid / req_stall  req_type, pos_x/y/z, corner_a/b/c
//   response   rsp_valid / rsp_stall  normal_x/y/z, status
//
// A face takes three position reads, six products on one shared multiplier
// and three sum updates. A query takes up to 18 shift steps, a 31-step
// square root and three 16-step divisions, one bit per cycle. A clear sweeps
// all 1024 entries of the sum store. After reset the same clearing pass runs
// with req_stall high. A two-entry queue lets requests enter while the back
// works, and a response register holds a result under rsp_stall.
module mesh_vertex_normal_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [1:0]         status
);
	import mvn_pkg::*;

	cmd_t push_cmd, head;
	logic push, full, head_valid, pop, init_busy;

	mvn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.corner_a  (corner_a),
		.corner_b  (corner_b),
		.corner_c  (corner_c),
		.init_busy (init_busy),
		.q_full    (full),
		.q_push    (push),
		.q_cmd     (push_cmd)
	);

	mvn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	mvn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.init_busy  (init_busy),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.normal_z   (normal_z),
		.status     (status)
	);

endmodule

/* sv/mvn_front.sv */
// mvn_front: accepts requests, tracks the vertex count and checks indices.
// Emits one classified command per request; depends on mvn_pkg.
module mvn_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    req_type,
	input  logic signed [15:0]            pos_x,
	input  logic signed [15:0]            pos_y,
	input  logic signed [15:0]            pos_z,
	input  logic [9:0]                    corner_a,
	input  logic [9:0]                    corner_b,
	input  logic [9:0]                    corner_c,
	input  logic                          init_busy,
	input  logic                          q_full,
	output logic                          q_push,
	output mvn_pkg::cmd_t                 q_cmd
);
	import mvn_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             a_out, b_out, c_out, full;

	assign req_stall = q_full | init_busy;
	assign q_push    = req_valid & ~req_stall;

	assign a_out = CNT_W'(corner_a) >= count_q;
	assign b_out = CNT_W'(corner_b) >= count_q;
	assign c_out = CNT_W'(corner_c) >= count_q;
	assign full  = count_q == CNT_W'(MAX_VERTS);

	// classify the request
	always_comb begin
		q_cmd        = '0;
		q_cmd.kind   = K_REPLY;
		q_cmd.status = ST_OK;
		q_cmd.idx_a  = corner_a;
		q_cmd.idx_b  = corner_b;
		q_cmd.idx_c  = corner_c;
		q_cmd.pos    = {pos_x, pos_y, pos_z};
		case (req_type)
			REQ_APPEND: begin
				if (full) begin
					q_cmd.status = ST_RANGE;
				end else begin
					q_cmd.kind  = K_APPEND;
					q_cmd.idx_a = count_q[IDX_W-1:0];
				end
			end
			REQ_FACE: begin
				if (a_out | b_out | c_out) q_cmd.status = ST_RANGE;
				else q_cmd.kind = K_FACE;
			end
			REQ_QUERY: begin
				if (a_out) q_cmd.status = ST_RANGE;
				else q_cmd.kind = K_QUERY;
			end
			REQ_CLEAR: q_cmd.kind = K_CLEAR;
			default: q_cmd.kind = K_REPLY;
		endcase
	end

	// advance the vertex count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			if (q_cmd.kind == K_APPEND) count_q <= count_q + CNT_W'(1);
			else if (q_cmd.kind == K_CLEAR) count_q <= '0;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTS))
		else $error("vertex count beyond store size");

endmodule

/* sv/mvn_queue.sv */
// mvn_queue: short command queue between the front and the back.
// Depends on mvn_pkg for the command type and depth.
module mvn_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mvn_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          head_valid,
	output mvn_pkg::cmd_t head,
	input  logic          pop
);
	import mvn_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] rd_ptr_q, wr_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full       = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rd_ptr_q];

	// hold entries
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push & ~pop) cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop & ~push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue pop while empty");

endmodule

/* sv/mvn_back.sv */
// mvn_back: sequencer that carries out commands on the position and sum stores,
// including cross product, saturating accumulation, square root and division.
// Depends on mvn_pkg.
module mvn_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  mvn_pkg::cmd_t            head,
	output logic                     pop,
	output logic                     init_busy,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic signed [15:0]       normal_x,
	output logic signed [15:0]       normal_y,
	output logic signed [15:0]       normal_z,
	output logic [1:0]               status
);
	import mvn_pkg::*;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int NSUM_W = 2 * DIFF_W + 1;
	localparam int MUL_W  = 31;
	localparam int PROD_W = 2 * MUL_W;
	localparam int MAG_W  = 30;
	localparam int SQ_W   = 2 * MAG_W + 2;
	localparam int LEN_W  = SQ_W / 2;
	localparam int QBITS  = 16;
	localparam int NUM_W  = MAG_W + 14 + 1;
	localparam int ENT_W  = 3 * ACC_W + 1;
	localparam int STEP_W = 5;

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_FRD    = 4'd2;
	localparam logic [3:0] S_MUL    = 4'd3;
	localparam logic [3:0] S_ACC_RD = 4'd4;
	localparam logic [3:0] S_ACC_WR = 4'd5;
	localparam logic [3:0] S_QRD    = 4'd6;
	localparam logic [3:0] S_QCHK   = 4'd7;
	localparam logic [3:0] S_SHIFT  = 4'd8;
	localparam logic [3:0] S_SQ     = 4'd9;
	localparam logic [3:0] S_SQRT   = 4'd10;
	localparam logic [3:0] S_DIV_LD = 4'd11;
	localparam logic [3:0] S_DIV_IT = 4'd12;
	localparam logic [3:0] S_OUT    = 4'd13;

	function automatic logic signed [COORD_BITS-1:0] crd(logic [POS_W-1:0] v, int i);
		return v[(2-i)*COORD_BITS +: COORD_BITS];
	endfunction

	function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] acc,
		logic signed [NSUM_W-1:0] d);
		logic [ACC_W:0] s;
		s = {acc[ACC_W-1], acc} + (ACC_W+1)'(d);
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s[ACC_W-1:0];
	endfunction

	// stores
	logic [POS_W-1:0] pos_mem [MAX_VERTS];
	logic [ENT_W-1:0] acc_mem [MAX_VERTS];
	logic [POS_W-1:0] pos_rd_q;
	logic [ENT_W-1:0] acc_rd_q;
	logic [IDX_W-1:0] pos_ra, acc_ra, acc_wa;
	logic             pos_we, acc_we;
	logic [ENT_W-1:0] acc_wd;

	// control
	logic [3:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        corner_q;
	logic              init_q;
	logic [IDX_W-1:0]  clr_q;
	cmd_t              cur_q;

	// datapath
	logic [POS_W-1:0]          p0_q, p1_q;
	logic signed [DIFF_W-1:0]  da_q [3];
	logic signed [DIFF_W-1:0]  db_q [3];
	logic signed [NSUM_W-1:0]  n_q [3];
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic [ACC_W-1:0]          m_q [3];
	logic                      neg_q [3];
	logic [SQ_W-1:0]           sumsq_q, sx_q, sr_q, bit_q;
	logic [LEN_W-1:0]          rem_q;
	logic [QBITS-1:0]          num_q, quo_q;
	logic signed [NRM_W-1:0]   res_q [3];
	logic [1:0]                res_st_q;

	// comb helpers
	logic [IDX_W-1:0]    corner_idx;
	logic [ACC_W-1:0]    m_sel;
	logic                neg_sel;
	logic [ACC_W-1:0]    sx, sy, sz;
	logic                used;
	logic [ACC_W-1:0]    mtop;
	logic [SQ_W-1:0]     sq_next, sq_t;
	logic [LEN_W-1:0]    len;
	logic [NUM_W-1:0]    num;
	logic [LEN_W:0]      r2;
	logic                ge;
	logic [QBITS-1:0]    qn, qc;
	logic [2:0]          km1;
	logic                out_free;

	assign init_busy = init_q;
	assign out_free  = ~rsp_valid | ~rsp_stall;
	assign pop       = (state_q == S_IDLE) & head_valid;

	always_comb begin
		case (corner_q)
			2'd0: begin corner_idx = cur_q.idx_a; m_sel = m_q[0]; neg_sel = neg_q[0]; end
			2'd1: begin corner_idx = cur_q.idx_b; m_sel = m_q[1]; neg_sel = neg_q[1]; end
			2'd2: begin corner_idx = cur_q.idx_c; m_sel = m_q[2]; neg_sel = neg_q[2]; end
			default: begin corner_idx = cur_q.idx_a; m_sel = '0; neg_sel = 1'b0; end
		endcase
	end

	assign used = acc_rd_q[ENT_W-1];
	assign sx   = acc_rd_q[3*ACC_W-1:2*ACC_W];
	assign sy   = acc_rd_q[2*ACC_W-1:ACC_W];
	assign sz   = acc_rd_q[ACC_W-1:0];
	assign mtop = m_q[0] | m_q[1] | m_q[2];
	assign sq_next = sumsq_q + SQ_W'($unsigned(prod_q));
	assign sq_t    = sr_q + bit_q;
	assign len     = sr_q[LEN_W-1:0];
	assign num     = {1'b0, m_sel[MAG_W-1:0], 14'b0} + NUM_W'(len >> 1);
	assign r2      = {rem_q, num_q[QBITS-1]};
	assign ge      = r2 >= {1'b0, len};
	assign qn      = {quo_q[QBITS-2:0], ge};
	assign qc      = (qn > QBITS'(ONE_Q14)) ? QBITS'(ONE_Q14) : qn;
	assign km1     = step_q[2:0] - 3'd1;

	// select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_MUL) begin
			case (step_q[2:0])
				3'd0: begin mul_a = MUL_W'(da_q[1]); mul_b = MUL_W'(db_q[2]); end
				3'd1: begin mul_a = MUL_W'(da_q[2]); mul_b = MUL_W'(db_q[1]); end
				3'd2: begin mul_a = MUL_W'(da_q[2]); mul_b = MUL_W'(db_q[0]); end
				3'd3: begin mul_a = MUL_W'(da_q[0]); mul_b = MUL_W'(db_q[2]); end
				3'd4: begin mul_a = MUL_W'(da_q[0]); mul_b = MUL_W'(db_q[1]); end
				3'd5: begin mul_a = MUL_W'(da_q[1]); mul_b = MUL_W'(db_q[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (state_q == S_SQ) begin
			mul_a = MUL_W'(m_sel[MAG_W-1:0]);
			mul_b = MUL_W'(m_sel[MAG_W-1:0]);
		end
	end

	// drive store ports
	always_comb begin
		pos_we = pop & (head.kind == K_APPEND);
		case (step_q[1:0])
			2'd0: pos_ra = cur_q.idx_a;
			2'd1: pos_ra = cur_q.idx_b;
			default: pos_ra = cur_q.idx_c;
		endcase
		acc_ra = (state_q == S_ACC_RD) ? corner_idx : cur_q.idx_a;
		acc_we = (state_q == S_CLR) | (state_q == S_ACC_WR);
		acc_wa = (state_q == S_CLR) ? clr_q : corner_idx;
		acc_wd = (state_q == S_CLR) ? '0 :
			{1'b1, sat_add(sx, n_q[0]), sat_add(sy, n_q[1]), sat_add(sz, n_q[2])};
	end

	// position store
	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[head.idx_a] <= head.pos;
		pos_rd_q <= pos_mem[pos_ra];
	end

	// sum store with used flag
	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_wa] <= acc_wd;
		acc_rd_q <= acc_mem[acc_ra];
	end

	// multiplier
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			step_q   <= '0;
			corner_q <= '0;
			init_q   <= 1'b1;
			clr_q    <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(MAX_VERTS - 1)) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_OUT;
					end
				end
				S_IDLE: begin
					step_q   <= '0;
					corner_q <= '0;
					clr_q    <= '0;
					if (head_valid) begin
						case (head.kind)
							K_FACE:  state_q <= S_FRD;
							K_QUERY: state_q <= S_QRD;
							K_CLEAR: state_q <= S_CLR;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_FRD: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(3)) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(6)) state_q <= S_ACC_RD;
				end
				S_ACC_RD: state_q <= S_ACC_WR;
				S_ACC_WR: begin
					corner_q <= corner_q + 2'd1;
					state_q  <= (corner_q == 2'd2) ? S_OUT : S_ACC_RD;
				end
				S_QRD: state_q <= S_QCHK;
				S_QCHK: begin
					if (!used || (sx == '0 && sy == '0 && sz == '0)) state_q <= S_OUT;
					else state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					step_q   <= '0;
					corner_q <= '0;
					if (mtop[ACC_W-1:MAG_W] == '0) state_q <= S_SQ;
				end
				S_SQ: begin
					step_q   <= step_q + STEP_W'(1);
					corner_q <= corner_q + 2'd1;
					if (step_q == STEP_W'(3)) begin
						step_q  <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(LEN_W - 1)) begin
						corner_q <= '0;
						state_q  <= S_DIV_LD;
					end
				end
				S_DIV_LD: begin
					step_q  <= '0;
					state_q <= S_DIV_IT;
				end
				S_DIV_IT: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(QBITS - 1)) begin
						corner_q <= corner_q + 2'd1;
						state_q  <= (corner_q == 2'd2) ? S_OUT : S_DIV_LD;
					end
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (head_valid) begin
					cur_q    <= head;
					res_q[0] <= '0;
					res_q[1] <= '0;
					res_q[2] <= '0;
					res_st_q <= (head.kind == K_REPLY) ? head.status : ST_OK;
				end
			end
			S_FRD: begin
				if (step_q == STEP_W'(1)) p0_q <= pos_rd_q;
				if (step_q == STEP_W'(2)) p1_q <= pos_rd_q;
				if (step_q == STEP_W'(3)) begin
					for (int i = 0; i < 3; i++) begin
						da_q[i] <= DIFF_W'(crd(p0_q, i)) - DIFF_W'(crd(pos_rd_q, i));
						db_q[i] <= DIFF_W'(crd(pos_rd_q, i)) - DIFF_W'(crd(p1_q, i));
					end
				end
			end
			S_MUL: begin
				if (step_q != '0) begin
					for (int i = 0; i < 3; i++) begin
						if (km1[2:1] == 2'(i)) begin
							if (km1[0]) n_q[i] <= n_q[i] - prod_q[NSUM_W-1:0];
							else n_q[i] <= prod_q[NSUM_W-1:0];
						end
					end
				end
			end
			S_QCHK: begin
				if (!used) begin
					res_q[1] <= NRM_W'(ONE_Q14);
					res_st_q <= ST_UNUSED;
				end else if (sx == '0 && sy == '0 && sz == '0) begin
					res_st_q <= ST_ZERO;
				end
				m_q[0]   <= sx[ACC_W-1] ? -sx : sx;
				m_q[1]   <= sy[ACC_W-1] ? -sy : sy;
				m_q[2]   <= sz[ACC_W-1] ? -sz : sz;
				neg_q[0] <= ~sx[ACC_W-1] & (sx != '0);
				neg_q[1] <= ~sy[ACC_W-1] & (sy != '0);
				neg_q[2] <= ~sz[ACC_W-1] & (sz != '0);
				sumsq_q  <= '0;
			end
			S_SHIFT: begin
				if (mtop[ACC_W-1:MAG_W] != '0) begin
					m_q[0] <= m_q[0] >> 1;
					m_q[1] <= m_q[1] >> 1;
					m_q[2] <= m_q[2] >> 1;
				end
			end
			S_SQ: begin
				if (step_q != '0) sumsq_q <= sq_next;
				if (step_q == STEP_W'(3)) begin
					sx_q  <= sq_next;
					sr_q  <= '0;
					bit_q <= SQ_W'(1) << (SQ_W - 2);
				end
			end
			S_SQRT: begin
				if (sx_q >= sq_t) begin
					sx_q <= sx_q - sq_t;
					sr_q <= (sr_q >> 1) + bit_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIV_LD: begin
				rem_q <= LEN_W'(num[NUM_W-1:QBITS]);
				num_q <= num[QBITS-1:0];
				quo_q <= '0;
			end
			S_DIV_IT: begin
				rem_q <= ge ? LEN_W'(r2 - {1'b0, len}) : r2[LEN_W-1:0];
				num_q <= num_q << 1;
				quo_q <= qn;
				if (step_q == STEP_W'(QBITS - 1)) begin
					for (int i = 0; i < 3; i++) begin
						if (corner_q == 2'(i))
							res_q[i] <= neg_sel ? -NRM_W'(qc) : NRM_W'(qc);
					end
				end
			end
			default: ;
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			normal_x <= res_q[0];
			normal_y <= res_q[1];
			normal_z <= res_q[2];
			status   <= res_st_q;
		end
	end

	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC_WR |-> $past(state_q) == S_ACC_RD)
		else $error("sum write without preceding read");

	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT |-> $onehot(bit_q))
		else $error("square root bit lost");

	a_unused_default: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free && res_st_q == ST_UNUSED)
		|=> normal_y == NRM_W'(ONE_Q14))
		else $error("unused vertex without default normal");

	a_no_pop_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !pop)
		else $error("command taken during clearing pass");

endmodule

/* tb/mvn_normal_checker.sv */
// mvn_normal_checker: watches both channels of the vertex normal engine, predicts each
// response from its own mirror of the vertex and sum stores, and compares field by field.
// Depends on mvn_pkg.
`timescale 1ns / 100ps

module mvn_normal_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic [1:0]         status,
	output int                 fails,
	output int                 pending
);
	import mvn_pkg::*;

	localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	typedef struct {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic [1:0]         st;
	} normal_rsp_t;

	// mirror of the block state
	longint      vert_pos [MAX_VERTS][3];
	longint      vert_sum [MAX_VERTS][3];
	bit          vert_used [MAX_VERTS];
	int          vert_cnt;
	normal_rsp_t normals_due[$];

	initial begin
		fails = 0;
		foreach (vert_sum[i, j]) vert_sum[i][j] = 0;
		foreach (vert_used[i]) vert_used[i] = 1'b0;
		vert_cnt = 0;
	end

	assign pending = normals_due.size();

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t: %s got %0d want %0d", $time, what, got, want);
		fails++;
	endtask

	function automatic longint sat_sum(input longint acc, input longint d);
		longint s;
		s = acc + d;
		if (s > SUM_MAX) return SUM_MAX;
		if (s < SUM_MIN) return SUM_MIN;
		return s;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// unit vector of the negated sum at one vertex
	function automatic normal_rsp_t vertex_normal(input int idx);
		normal_rsp_t r;
		longint unsigned mag [3];
		bit neg [3];
		longint unsigned top, len, q;
		longint comp [3];
		r = '{0, 0, 0, ST_OK};
		if (idx >= vert_cnt) begin
			r.st = ST_RANGE;
			return r;
		end
		if (!vert_used[idx]) begin
			r.ny = 16'(ONE_Q14);
			r.st = ST_UNUSED;
			return r;
		end
		if (vert_sum[idx][0] == 0 && vert_sum[idx][1] == 0 && vert_sum[idx][2] == 0) begin
			r.st = ST_ZERO;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			neg[i] = vert_sum[idx][i] > 0;
			mag[i] = vert_sum[idx][i] < 0 ? -vert_sum[idx][i] : vert_sum[idx][i];
		end
		top = mag[0] | mag[1] | mag[2];
		while (top >= (64'd1 << 30)) begin
			top >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] * ONE_Q14 + len / 2) / len;
			if (q > ONE_Q14) q = ONE_Q14;
			comp[i] = neg[i] ? -longint'(q) : longint'(q);
		end
		r.nx = comp[0][15:0];
		r.ny = comp[1][15:0];
		r.nz = comp[2][15:0];
		return r;
	endfunction

	// apply one request to the mirror and return its response
	function automatic normal_rsp_t apply_request(input logic [1:0] kind,
			input logic signed [15:0] px, py, pz, input int ca, cb, cc);
		normal_rsp_t r;
		longint a [3], b [3], n [3];
		int crn [3];
		r = '{0, 0, 0, ST_OK};
		crn = '{ca, cb, cc};
		case (kind)
			REQ_APPEND: begin
				if (vert_cnt >= MAX_VERTS) begin
					r.st = ST_RANGE;
				end else begin
					vert_pos[vert_cnt] = '{px, py, pz};
					vert_cnt++;
				end
			end
			REQ_FACE: begin
				if (ca >= vert_cnt || cb >= vert_cnt || cc >= vert_cnt) begin
					r.st = ST_RANGE;
				end else begin
					for (int j = 0; j < 3; j++) begin
						a[j] = vert_pos[ca][j] - vert_pos[cc][j];
						b[j] = vert_pos[cc][j] - vert_pos[cb][j];
					end
					n[0] = a[1] * b[2] - a[2] * b[1];
					n[1] = a[2] * b[0] - a[0] * b[2];
					n[2] = a[0] * b[1] - a[1] * b[0];
					// each corner adds once, repeated corners included
					foreach (crn[k]) begin
						for (int j = 0; j < 3; j++)
							vert_sum[crn[k]][j] = sat_sum(vert_sum[crn[k]][j], n[j]);
						vert_used[crn[k]] = 1'b1;
					end
				end
			end
			REQ_QUERY: r = vertex_normal(ca);
			REQ_CLEAR: begin
				foreach (vert_sum[i, j]) vert_sum[i][j] = 0;
				foreach (vert_used[i]) vert_used[i] = 1'b0;
				vert_cnt = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// predict on each accepted request, compare each accepted response
	always @(posedge clk) begin
		normal_rsp_t due, want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				due = apply_request(req_type, pos_x, pos_y, pos_z,
					corner_a, corner_b, corner_c);
				normals_due.insert(normals_due.size(), due);
			end
			if (rsp_valid && !rsp_stall) begin
				if (normals_due.size() == 0) begin
					report("response with none due, status", status, 0);
				end else begin
					want = normals_due.pop_front();
					if (normal_x !== want.nx) report("normal_x", normal_x, want.nx);
					if (normal_y !== want.ny) report("normal_y", normal_y, want.ny);
					if (normal_z !== want.nz) report("normal_z", normal_z, want.nz);
					if (status !== want.st) report("status", status, want.st);
				end
			end
		end
	end

endmodule

/* tb/mesh_vertex_normal_engine_tb.sv */
// mesh_vertex_normal_engine_tb: drives directed, store-full, large-sum and random mesh
// requests into the engine under several idle and stall mixes and gives the verdict.
// Depends on mvn_pkg, mesh_vertex_normal_engine and mvn_normal_checker.
`timescale 1ns / 100ps

module mesh_vertex_normal_engine_tb;
	import mvn_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [1:0]         req_type;
	logic signed [15:0] pos_x, pos_y, pos_z;
	logic [9:0]         corner_a, corner_b, corner_c;
	logic               rsp_valid;
	logic               rsp_stall;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [1:0]         status;
	int                 fails;
	int                 pending;

	int idle_pct;
	int stall_pct;
	int verts_known;

	mesh_vertex_normal_engine u_dut (.*);

	mvn_normal_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("Mismatches found");
		$finish;
	end

	// receiver stall
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// send one request; hold it until accepted
	task automatic send(input logic [1:0] kind, input logic signed [15:0] x, y, z,
			input int ca, cb, cc);
		while ($urandom_range(99) < idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req_type  = kind;
		pos_x     = x;
		pos_y     = y;
		pos_z     = z;
		corner_a  = 10'(ca);
		corner_b  = 10'(cb);
		corner_c  = 10'(cc);
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		if (kind == REQ_APPEND && verts_known < MAX_VERTS) verts_known++;
		if (kind == REQ_CLEAR) verts_known = 0;
	endtask

	task automatic append(input logic signed [15:0] x, y, z);
		send(REQ_APPEND, x, y, z, $urandom_range(1023), $urandom_range(1023),
			$urandom_range(1023));
	endtask

	task automatic append_random();
		append(16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic face(input int ca, cb, cc);
		send(REQ_FACE, 16'($urandom), 16'($urandom), 16'($urandom), ca, cb, cc);
	endtask

	task automatic query(input int idx);
		send(REQ_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), idx,
			$urandom_range(1023), $urandom_range(1023));
	endtask

	task automatic clear_all();
		send(REQ_CLEAR, '0, '0, '0, 0, 0, 0);
	endtask

	// mostly in range, sometimes any index
	function automatic int pick_corner();
		if (verts_known > 0 && $urandom_range(99) < 92) return $urandom_range(verts_known - 1);
		return $urandom_range(1023);
	endfunction

	task automatic random_request();
		int roll;
		roll = $urandom_range(999);
		if (roll < 6) send(REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
			$urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
		else if (verts_known < 3 || roll < (verts_known > 60 ? 60 : 300))
			append_random();
		else if (roll < 650) face(pick_corner(), pick_corner(), pick_corner());
		else query(pick_corner());
	endtask

	initial begin
		idle_pct = 0;
		stall_pct = 0;
		verts_known = 0;
		req_valid = 1'b0;
		req_type = REQ_APPEND;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		corner_a = '0;
		corner_b = '0;
		corner_c = '0;
		rsp_stall = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty store, extremes, unused, zero sum, range
		query(0);
		face(0, 1, 2);
		append(16'sh7FFF, -16'sh8000, 16'sh0000);
		append(-16'sh8000, 16'sh7FFF, -16'sh8000);
		append(-16'sh8000, -16'sh8000, 16'sh7FFF);
		append(16'sh0000, 16'sh0000, 16'sh0000);
		append(-16'sh0001, -16'sh0001, -16'sh0001);
		query(0);
		face(0, 1, 2);
		face(2, 1, 0);
		face(0, 1, 2);
		query(0);
		query(1);
		query(2);
		face(3, 3, 4);
		query(3);
		query(4);
		query(5);
		query(1023);
		face(0, 1, 1023);
		clear_all();
		query(0);

		// fill the store, then overflow it
		repeat (MAX_VERTS + 1) append_random();
		face(1021, 1022, 1023);
		query(1023);
		query(1021);
		query(0);
		clear_all();

		// drive the z sums far past the normalization range, then back off
		append(16'sh7FFF, -16'sh8000, 16'sh0000);
		append(-16'sh8000, 16'sh7FFF, 16'sh0000);
		append(-16'sh8000, -16'sh8000, 16'sh0000);
		repeat (60) face(0, 1, 2);
		query(0);
		repeat (10) face(0, 2, 1);
		query(0);
		query(2);
		clear_all();

		// random traffic under each idle and stall mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 85; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 85; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase
			repeat (250) random_request();
		end

		// drain
		req_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
